FILE: src/deq_pkg.sv
package deq_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_LIST      = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_REAR  = 3'd4
    } cmd_op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_LISTED   = 3'd4
    } status_t;

    typedef struct packed {
        cmd_op_t op;
        word_t   value;
    } cmd_t;

    localparam int CMDQ_DEPTH = 2;

endpackage

FILE: src/deq_if.sv
interface deq_in_if;
    import deq_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  action;
    word_t       value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  status;
    word_t       value_res;
    logic        last;

    modport source (output valid, output status, output value_res, output last, input ready);
    modport sink (input valid, input status, input value_res, input last, output ready);
endinterface

FILE: src/deq_front.sv
module deq_front
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    deq_in_if.sink   req,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_ready
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             q_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;
    logic             act_ok;

    // unused action codes are taken and dropped
    assign act_ok    = (req.action <= 3'(OP_REM_REAR));
    assign req.ready = (cnt_reg != CNT_W'(CMDQ_DEPTH));
    assign push      = req.valid && req.ready && act_ok;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= '{op: cmd_op_t'(req.action), value: req.value};
        end
    end

endmodule

FILE: src/deq_back.sv
module deq_back
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmd_t     cmd,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    deq_out_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REM,
        S_LIST
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    word_t            out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    word_t            mem [DEPTH];
    word_t            rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic             out_free;
    logic             out_load;
    logic             take;
    logic             is_empty;
    logic             is_full;

    function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] inc_mod(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_res = out_value_reg;
    assign rsp.last      = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = 1'b1;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (cmd.op)
                        OP_INS_FRONT, OP_INS_REAR:
                        begin
                            out_load       = 1'b1;
                            out_value_next = '0;
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_status_next = ST_INSERTED;
                                wr_en           = 1'b1;
                                count_next      = count_reg + 1'b1;
                                if (cmd.op == OP_INS_FRONT)
                                begin
                                    head_next = (head_reg == '0) ? IDX_W'(DEPTH - 1)
                                                                 : head_reg - 1'b1;
                                    wr_addr   = head_next;
                                end
                                else
                                begin
                                    wr_addr = add_mod(head_reg, count_reg);
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_value_next  = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                pos_next   = inc_mod(head_reg);
                                rem_next   = IDX_W'(count_reg - 1'b1);
                                state_next = S_LIST;
                            end
                        end
                        OP_REM_FRONT, OP_REM_REAR:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_value_next  = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = S_REM;
                                if (cmd.op == OP_REM_FRONT)
                                begin
                                    rd_addr   = head_reg;
                                    head_next = inc_mod(head_reg);
                                end
                                else
                                begin
                                    rd_addr = add_mod(head_reg, count_reg - 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REM:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_REMOVED;
                    out_value_next  = rd_data_reg;
                    state_next      = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_LISTED;
                    out_value_next  = rd_data_reg;
                    out_last_next   = (rem_reg == '0);
                    if (rem_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg;
                        pos_next = inc_mod(pos_reg);
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rsp.ready;
            out_last_next  = out_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: src/double_ended_queue.sv
// An insert or an empty answer passes through the command queue and the output register;
// a removal also passes through the registered ring read before the output register.
// The back end takes no new command while a removal or a listing is in progress, as the
// ring has a single read port; a 2-entry command queue lets input run ahead.
// Reset (rst_n, async, active low): queue empty, head at 0, no result pending.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    deq_in_if.sink     req,
    deq_out_if.source  rsp
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule
